>>> sv/sacfd_pkg.sv
// shared types and constants for the sos click and fall alert detector
// no dependencies; imported by every module of the block

package sacfd_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned TallyW = 4;
	localparam int unsigned DelayW = 31;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [TimeW-1:0] ClickWindowRst = 32'd1500;
	localparam logic [TallyW-1:0] ClicksNeededRst = 4'd3;
	localparam logic [DelayW-1:0] ConfirmDelayRst = 31'd5000;
	localparam logic [TimeW-1:0] FallTimeoutRst = 32'd10000;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_CLICK_WINDOW  = 2'd0,
		REG_CLICKS_NEEDED = 2'd1,
		REG_CONFIRM_DELAY = 2'd2,
		REG_FALL_TIMEOUT  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [TimeW-1:0]  click_window_ms;
		logic [TallyW-1:0] clicks_needed;
		logic [DelayW-1:0] confirm_delay_ms;
		logic [TimeW-1:0]  fall_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0] now_ms;
		logic             button_low;
		logic             sample_valid;
		logic             freefall;
		logic             inactivity;
	} item_t;

	typedef struct packed {
		logic sos_alert;
		logic fall_alert;
		logic sos_armed;
		logic fall_watching;
	} result_t;

endpackage

>>> sv/sacfd_cfg.sv
// configuration register file of the sos click and fall alert detector
// depends on sacfd_pkg

module sacfd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sacfd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [sacfd_pkg::TimeW-1:0]     cfg_data,
	output sacfd_pkg::cfg_t                 cfg
);
	import sacfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_window_ms  <= ClickWindowRst;
			cfg_q.clicks_needed    <= ClicksNeededRst;
			cfg_q.confirm_delay_ms <= ConfirmDelayRst;
			cfg_q.fall_timeout_ms  <= FallTimeoutRst;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CLICK_WINDOW:  cfg_q.click_window_ms  <= cfg_data;
				REG_CLICKS_NEEDED: cfg_q.clicks_needed    <= cfg_data[TallyW-1:0];
				REG_CONFIRM_DELAY: cfg_q.confirm_delay_ms <= cfg_data[DelayW-1:0];
				REG_FALL_TIMEOUT:  cfg_q.fall_timeout_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/sacfd_sos.sv
// click counting and pending sos state with its deadline check
// depends on sacfd_pkg

module sacfd_sos (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [sacfd_pkg::TimeW-1:0] now_ms,
	input  logic                        button_low,
	input  sacfd_pkg::cfg_t             cfg,
	output logic                        sos_alert,
	output logic                        sos_armed
);
	import sacfd_pkg::*;

	logic              prev_button_q;
	logic [TallyW-1:0] tally_q;
	logic [TimeW-1:0]  last_click_q;
	logic              waiting_q;
	logic [TimeW-1:0]  deadline_q;

	logic              click;
	logic              cancel;
	logic              counted;
	logic [TimeW-1:0]  gap;
	logic [TallyW-1:0] tally_base;
	logic [TallyW-1:0] tally_inc;
	logic              arm;
	logic [TimeW-1:0]  since_deadline;
	logic              fire;
	logic              waiting_d;
	logic [TallyW-1:0] tally_d;

	always_comb begin
		click      = button_low & ~prev_button_q;
		cancel     = click & waiting_q;
		counted    = click & ~waiting_q;
		gap        = now_ms - last_click_q;
		tally_base = (gap > cfg.click_window_ms) ? '0 : tally_q;
		tally_inc  = tally_base + TallyW'(1);
		arm        = counted & (tally_inc >= cfg.clicks_needed);
		since_deadline = now_ms - deadline_q;
		// a fresh deadline is due at once only with a zero delay
		fire = arm ? (cfg.confirm_delay_ms == '0)
		           : (waiting_q & ~cancel & ~since_deadline[TimeW-1]);
		waiting_d = (arm | (waiting_q & ~cancel)) & ~fire;
		if (cancel || arm) begin
			tally_d = '0;
		end else if (counted) begin
			tally_d = tally_inc;
		end else begin
			tally_d = tally_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_button_q <= 1'b0;
			tally_q       <= '0;
			last_click_q  <= '0;
			waiting_q     <= 1'b0;
			deadline_q    <= '0;
		end else if (step) begin
			prev_button_q <= button_low;
			tally_q       <= tally_d;
			waiting_q     <= waiting_d;
			if (counted) begin
				last_click_q <= now_ms;
			end
			if (arm) begin
				deadline_q <= now_ms + TimeW'(cfg.confirm_delay_ms);
			end
		end
	end

	assign sos_alert = fire;
	assign sos_armed = waiting_d;

endmodule

>>> sv/sacfd_fall.sv
// fall watch: freefall edge, stillness tracking and timeout
// depends on sacfd_pkg

module sacfd_fall (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [sacfd_pkg::TimeW-1:0] now_ms,
	input  logic                        sample_valid,
	input  logic                        freefall,
	input  logic                        inactivity,
	input  sacfd_pkg::cfg_t             cfg,
	output logic                        fall_alert,
	output logic                        fall_watching
);
	import sacfd_pkg::*;

	logic             prev_ff_q;
	logic             watch_q;
	logic [TimeW-1:0] fall_time_q;
	logic             still_q;

	logic             start;
	logic             watch_mid;
	logic             still_mid;
	logic             moved;
	logic             still_d;
	logic [TimeW-1:0] elapsed;
	logic             timed_out;
	logic             fire;
	logic             watch_d;

	always_comb begin
		start     = sample_valid & freefall & ~prev_ff_q;
		watch_mid = start | watch_q;
		still_mid = start ? 1'b0 : still_q;
		moved     = ~inactivity & still_mid;
		still_d   = still_mid | (watch_mid & inactivity);
		// elapsed time is zero on the tick that starts the watch
		elapsed   = start ? '0 : (now_ms - fall_time_q);
		timed_out = elapsed >= cfg.fall_timeout_ms;
		fire      = sample_valid & watch_mid & ~moved & still_d & timed_out;
		if (!sample_valid) begin
			watch_d = watch_q;
		end else begin
			watch_d = watch_mid & ~moved & ~fire;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ff_q   <= 1'b0;
			watch_q     <= 1'b0;
			fall_time_q <= '0;
			still_q     <= 1'b0;
		end else if (step && sample_valid) begin
			prev_ff_q <= freefall;
			watch_q   <= watch_d;
			if (start) begin
				fall_time_q <= now_ms;
			end
			if (watch_mid) begin
				still_q <= still_d;
			end
		end
	end

	assign fall_alert    = fire;
	assign fall_watching = watch_d;

endmodule

>>> sv/sos_click_and_fall_alert_detector_top.sv
// top level of the sos click and fall alert detector
// depends on sacfd_pkg, sacfd_cfg, sacfd_sos and sacfd_fall

// usage
// - input channel (in_valid/in_ready): one item per update tick, carrying the
//   millisecond timestamp, the button level and an optional motion sample
// - output channel (out_valid/out_ready): exactly one result item per input
//   item, in order: sos_alert, fall_alert, sos_armed, fall_watching
// - configuration: cfg_we writes cfg_data into register cfg_index at the
//   clock edge; 0 click window, 1 clicks needed, 2 confirm delay,
//   3 fall timeout; write only while no item is in flight
// - pipeline: the input register loads at the accept edge; the result register
//   and the detector state load together when the step runs, which waits while
//   an untaken result occupies the result register
// - throughput: one item per cycle while out_ready stays high; the step is
//   a handful of 32-bit compares and subtracts between the two registers
// - a stalled receiver holds the result register; the input register still
//   takes one more item, then in_ready drops until the result is taken
// - reset (arst_n low) clears the pipeline valid flags and all detector
//   state, and loads the configuration reset values

module sos_click_and_fall_alert_detector_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sacfd_pkg::TimeW-1:0]     now_ms,
	input  logic                            button_low,
	input  logic                            sample_valid,
	input  logic                            freefall,
	input  logic                            inactivity,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            sos_alert,
	output logic                            fall_alert,
	output logic                            sos_armed,
	output logic                            fall_watching,
	input  logic                            cfg_we,
	input  logic [sacfd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [sacfd_pkg::TimeW-1:0]     cfg_data
);
	import sacfd_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_d;
	logic    advance;

	// the step runs when stage 1 holds an item and the result slot frees up
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;

	sacfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sacfd_sos u_sos (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.now_ms     (item_s1.now_ms),
		.button_low (item_s1.button_low),
		.cfg        (cfg),
		.sos_alert  (res_d.sos_alert),
		.sos_armed  (res_d.sos_armed)
	);

	sacfd_fall u_fall (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.now_ms        (item_s1.now_ms),
		.sample_valid  (item_s1.sample_valid),
		.freefall      (item_s1.freefall),
		.inactivity    (item_s1.inactivity),
		.cfg           (cfg),
		.fall_alert    (res_d.fall_alert),
		.fall_watching (res_d.fall_watching)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.now_ms       <= now_ms;
			item_s1.button_low   <= button_low;
			item_s1.sample_valid <= sample_valid;
			item_s1.freefall     <= freefall;
			item_s1.inactivity   <= inactivity;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign sos_alert     = res_s2.sos_alert;
	assign fall_alert    = res_s2.fall_alert;
	assign sos_armed     = res_s2.sos_armed;
	assign fall_watching = res_s2.fall_watching;

	// a firing alert always leaves its pending state cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sos_alert |-> !sos_armed)
		else $error("sos alert with sos still armed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fall_alert |-> !fall_watching)
		else $error("fall alert with watch still active");

	// an item waiting in stage 1 with a free result slot moves on next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> out_valid)
		else $error("stage 1 item did not reach the result register");

	// stage 1 never drops ready while it is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty input register");

endmodule

>>> tb/sos_click_and_fall_alert_detector_top_test.sv
// self-checking testbench for the sos click and fall alert detector top level
// depends on sacfd_pkg and sos_click_and_fall_alert_detector_top; an in-bench predictor
// tracks the detector state and checks every result item in order

module sos_click_and_fall_alert_detector_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sacfd_pkg::*;

	localparam int HoldMax = 5;      // longest random wait of either side, in cycles
	localparam int QuietLimit = 500; // cycles without any handshake before giving up
	localparam int ReportMax = 10;   // mismatches printed in full

	// clock, reset and ports; the bench-driven inputs are known from time zero
	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TimeW-1:0] now_ms = '0;
	logic button_low = 1'b0;
	logic sample_valid = 1'b0;
	logic freefall = 1'b0;
	logic inactivity = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic sos_alert;
	logic fall_alert;
	logic sos_armed;
	logic fall_watching;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [TimeW-1:0] cfg_data = '0;

	sos_click_and_fall_alert_detector_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.now_ms        (now_ms),
		.button_low    (button_low),
		.sample_valid  (sample_valid),
		.freefall      (freefall),
		.inactivity    (inactivity),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sos_alert     (sos_alert),
		.fall_alert    (fall_alert),
		.sos_armed     (sos_armed),
		.fall_watching (fall_watching),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predictor copy of the register settings
	logic [TimeW-1:0]  cf_window  = ClickWindowRst;
	logic [TallyW-1:0] cf_needed  = ClicksNeededRst;
	logic [DelayW-1:0] cf_delay   = ConfirmDelayRst;
	logic [TimeW-1:0]  cf_timeout = FallTimeoutRst;

	// predictor copy of the detector state, all zero after reset
	logic              md_btn = 1'b0;
	logic [TallyW-1:0] md_tally = '0;
	logic [TimeW-1:0]  md_last_click = '0;
	logic              md_armed = 1'b0;
	logic [TimeW-1:0]  md_deadline = '0;
	logic              md_prev_ff = 1'b0;
	logic              md_watch = 1'b0;
	logic [TimeW-1:0]  md_fall_t = '0;
	logic              md_still = 1'b0;

	// results owed by the block, oldest first
	result_t awaited[$];

	// running timestamp of the stimulus, wraps like the real counter
	logic [TimeW-1:0] t_ms = '0;
	// when set, neither side inserts waits
	bit no_idle = 1'b0;

	int ticks_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int settings_used = 0;
	int sos_fired = 0;
	int falls_fired = 0;
	int sos_cancels = 0;
	int watch_drops = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	result_t got;
	result_t want;

	// one update tick of the detector: button half first, then the motion half
	function automatic result_t advance_detector(input item_t it);
		result_t r;
		logic press;
		logic cancelled;
		logic [TimeW-1:0] gap;
		logic [TimeW-1:0] late;
		r = '0;
		cancelled = 1'b0;
		press = it.button_low && !md_btn;
		md_btn = it.button_low;
		if (press) begin
			if (md_armed) begin
				// a click while armed calls the sos off, no alert this tick
				md_armed = 1'b0;
				md_tally = '0;
				cancelled = 1'b1;
				sos_cancels++;
			end else begin
				gap = it.now_ms - md_last_click;
				if (gap > cf_window) md_tally = '0;
				md_last_click = it.now_ms;
				md_tally = md_tally + 1'b1;
				if (md_tally >= cf_needed) begin
					md_armed = 1'b1;
					md_deadline = it.now_ms + {1'b0, cf_delay};
					md_tally = '0;
				end
			end
		end
		// deadline reached when now minus deadline is not negative as a signed value
		late = it.now_ms - md_deadline;
		if (!cancelled && md_armed && !late[TimeW-1]) begin
			md_armed = 1'b0;
			r.sos_alert = 1'b1;
		end
		// no motion sample: fall state holds, previous freefall too
		if (it.sample_valid) begin
			if (it.freefall && !md_prev_ff) begin
				md_watch = 1'b1;
				md_fall_t = it.now_ms;
				md_still = 1'b0;
			end
			md_prev_ff = it.freefall;
			if (md_watch) begin
				if (it.inactivity) md_still = 1'b1;
				if (!it.inactivity && md_still) begin
					// renewed movement after stillness ends the watch
					md_watch = 1'b0;
					watch_drops++;
				end else if (md_still && (it.now_ms - md_fall_t) >= cf_timeout) begin
					md_watch = 1'b0;
					r.fall_alert = 1'b1;
				end
			end
		end
		r.sos_armed = md_armed;
		r.fall_watching = md_watch;
		return r;
	endfunction

	function automatic logic [TimeW-1:0] cap(input logic [TimeW-1:0] v,
		input logic [TimeW-1:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// spacing between button edges: mostly inside the window, sometimes past it
	function automatic logic [TimeW-1:0] click_gap(input logic [TimeW-1:0] win);
		case ($urandom_range(0, 19))
			0, 1: begin
				return '0;
			end
			2, 3, 4: begin
				return $urandom_range(win / 2, win + win / 2 + 2);
			end
			default: begin
				return $urandom_range(0, win / 2);
			end
		endcase
	endfunction

	// time steps while an sos is pending; huge delays get whole-range jumps
	function automatic logic [TimeW-1:0] delay_step();
		if (cf_delay > 100000) return $urandom;
		return $urandom_range(0, {1'b0, cf_delay} + 2);
	endfunction

	function automatic logic [TimeW-1:0] fall_step(input logic [TimeW-1:0] span);
		if ($urandom_range(0, 15) == 0) return $urandom;
		return $urandom_range(0, span);
	endfunction

	// send one item: random wait, hold valid until taken, then log the prediction
	task automatic send_item(input item_t it);
		int gap;
		result_t r;
		gap = no_idle ? 0 : $urandom_range(0, HoldMax);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= it.now_ms;
		button_low <= it.button_low;
		sample_valid <= it.sample_valid;
		freefall <= it.freefall;
		inactivity <= it.inactivity;
		do @(posedge clk); while (!in_ready);
		r = advance_detector(it);
		awaited.push_back(r);
		ticks_sent++;
		if (r.sos_alert) sos_fired++;
		if (r.fall_alert) falls_fired++;
	endtask

	task automatic tick(input logic [TimeW-1:0] dt, input logic btn, input logic sv,
		input logic ff, input logic still);
		item_t it;
		t_ms = t_ms + dt;
		it.now_ms = t_ms;
		it.button_low = btn;
		it.sample_valid = sv;
		it.freefall = ff;
		it.inactivity = still;
		send_item(it);
	endtask

	// button tick with a random motion sample riding along
	task automatic noisy_tick(input logic [TimeW-1:0] dt, input logic btn);
		tick(dt, btn, $urandom_range(0, 3) == 0, coin(), coin());
	endtask

	// drain: stop sending, wait for every owed result, then a few spare cycles
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register writes only ever happen with the pipeline empty
	task automatic write_reg(input cfg_reg_t idx, input logic [TimeW-1:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CLICK_WINDOW: begin
				cf_window = val;
			end
			REG_CLICKS_NEEDED: begin
				cf_needed = val[TallyW-1:0];
			end
			REG_CONFIRM_DELAY: begin
				cf_delay = val[DelayW-1:0];
			end
			REG_FALL_TIMEOUT: begin
				cf_timeout = val;
			end
			default: begin
			end
		endcase
	endtask

	// a run of presses and releases, then waiting around the deadline
	task automatic click_burst();
		logic [TimeW-1:0] win;
		int presses;
		int waits;
		win = cap(cf_window, 32'd3000);
		presses = $urandom_range(1, cf_needed + 1);
		for (int i = 0; i < presses; i++) begin
			noisy_tick(click_gap(win), 1'b1);
			noisy_tick(click_gap(win), 1'b0);
		end
		waits = $urandom_range(1, 4);
		for (int i = 0; i < waits; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				// an extra click, which cancels if the sos is pending
				noisy_tick(click_gap(win), 1'b1);
				noisy_tick(click_gap(win), 1'b0);
			end else begin
				noisy_tick(delay_step(), 1'b0);
			end
		end
	endtask

	// freefall edge, then a mix of stillness, movement, gaps and new edges
	task automatic fall_episode();
		logic [TimeW-1:0] span;
		int steps;
		span = cap(cf_timeout, 32'd20000) / 3 + 1;
		if (md_prev_ff) tick(fall_step(span), md_btn, 1'b1, 1'b0, coin());
		tick(fall_step(span), md_btn, 1'b1, 1'b1, coin());
		steps = $urandom_range(2, 8);
		for (int i = 0; i < steps; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					tick(fall_step(span), md_btn, 1'b0, coin(), coin());
				end
				1: begin
					tick(fall_step(span), md_btn, 1'b1, 1'b0, 1'b0);
				end
				2: begin
					tick(fall_step(span), md_btn, 1'b1, 1'b1, coin());
				end
				3: begin
					tick(fall_step(span), coin(), 1'b1, 1'b0, 1'b1);
				end
				default: begin
					tick(fall_step(span), md_btn, 1'b1, 1'b0, 1'b1);
				end
			endcase
		end
	endtask

	// fully random ticks, with occasional jumps across the whole timestamp range
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			tick(coin() ? $urandom : $urandom_range(0, 2000), coin(), coin(), coin(), coin());
		end
	endtask

	// one register setting and a stretch of mixed random traffic under it
	task automatic run_phase(input logic [TimeW-1:0] win, input logic [TimeW-1:0] needed,
		input logic [TimeW-1:0] delay, input logic [TimeW-1:0] tmo, input bit quiet,
		input int count);
		int stop_at;
		write_reg(REG_CLICK_WINDOW, win);
		write_reg(REG_CLICKS_NEEDED, needed);
		write_reg(REG_CONFIRM_DELAY, delay);
		write_reg(REG_FALL_TIMEOUT, tmo);
		settings_used++;
		stop_at = ticks_sent + count;
		while (ticks_sent < stop_at) begin
			// stretches without any waits, always in a quiet phase
			no_idle = quiet || ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					click_burst();
				end
				8, 9, 10, 11, 12, 13, 14: begin
					fall_episode();
				end
				default: begin
					noise_burst();
				end
			endcase
		end
		no_idle = 1'b0;
	endtask

	// reset settings: three clicks across the timestamp wrap arm, the deadline fires
	task automatic test_click_arm_and_fire();
		settings_used++;
		t_ms = '1;
		tick(0, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(1, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(10, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(10, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(10, 1'b1, 1'b0, 1'b0, 1'b0);
		// held button before the deadline, then the deadline itself
		tick(3970, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(1030, 1'b0, 1'b0, 1'b0, 1'b0);
	endtask

	// single-click arming, and a click while armed cancelling it
	task automatic test_cancel_while_armed();
		write_reg(REG_CLICKS_NEEDED, 32'd1);
		settings_used++;
		tick(2000, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(10, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(10, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(6000, 1'b0, 1'b0, 1'b0, 1'b0);
	endtask

	// zero click count with zero delay fires on the arming tick; zero window
	// restarts the tally on any gap but a zero gap still continues it
	task automatic test_zero_count_and_window();
		write_reg(REG_CLICKS_NEEDED, 32'd0);
		write_reg(REG_CONFIRM_DELAY, 32'd0);
		settings_used++;
		tick(10, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(10, 1'b0, 1'b0, 1'b0, 1'b0);
		write_reg(REG_CLICKS_NEEDED, 32'd2);
		write_reg(REG_CLICK_WINDOW, 32'd0);
		settings_used++;
		tick(10, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(0, 1'b0, 1'b0, 1'b0, 1'b0);
		tick(0, 1'b1, 1'b0, 1'b0, 1'b0);
		tick(10, 1'b0, 1'b0, 1'b0, 1'b0);
	endtask

	// fall watch: no sample holds, early movement, restart, cancel and timeout
	task automatic test_fall_watch();
		write_reg(REG_FALL_TIMEOUT, 32'd500);
		settings_used++;
		tick(10, 1'b0, 1'b0, 1'b1, 1'b1);
		tick(10, 1'b0, 1'b1, 1'b1, 1'b0);
		tick(10, 1'b0, 1'b1, 1'b0, 1'b0);
		tick(100, 1'b0, 1'b1, 1'b1, 1'b0);
		tick(10, 1'b0, 1'b1, 1'b1, 1'b1);
		tick(10, 1'b0, 1'b1, 1'b0, 1'b0);
		tick(10, 1'b0, 1'b1, 1'b1, 1'b1);
		tick(500, 1'b0, 1'b1, 1'b0, 1'b1);
	endtask

	task automatic test_random_reset_values();
		run_phase(32'd1500, 32'd3, 32'd5000, 32'd10000, 1'b0, 100);
	endtask

	// every register at its floor but clicks needed at one, with no waits on either side
	task automatic test_random_floor();
		run_phase(32'd0, 32'd1, 32'd0, 32'd0, 1'b1, 100);
	endtask

	// every register at its ceiling; the delay write also sets the unused top bit
	task automatic test_random_ceiling();
		run_phase('1, 32'd15, '1, '1, 1'b0, 100);
	endtask

	task automatic test_random_settings();
		logic [TimeW-1:0] win;
		for (int i = 0; i < 4; i++) begin
			win = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
			run_phase(win, $urandom_range(1, 6), $urandom_range(0, 4000),
				$urandom_range(0, 8000), 1'b0, 100);
		end
	endtask

	// result side: random stalls per item, compare against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				got.sos_alert = sos_alert;
				got.fall_alert = fall_alert;
				got.sos_armed = sos_armed;
				got.fall_watching = fall_watching;
				if (awaited.size() == 0) begin
					mismatches++;
					if (mismatches <= ReportMax)
						$display("result %0d arrived with no tick awaiting it", results_seen);
				end else begin
					want = awaited.pop_front();
					if (got.sos_alert !== want.sos_alert || got.fall_alert !== want.fall_alert
						|| got.sos_armed !== want.sos_armed
						|| got.fall_watching !== want.fall_watching) begin
						mismatches++;
						if (mismatches <= ReportMax) begin
							$display("result %0d: expected %s=%b %s=%b %s=%b %s=%b",
								results_seen, "sos_alert", want.sos_alert,
								"fall_alert", want.fall_alert, "sos_armed",
								want.sos_armed, "fall_watching", want.fall_watching);
							$display("  got sos_alert=%b fall_alert=%b %s=%b %s=%b",
								got.sos_alert, got.fall_alert, "sos_armed",
								got.sos_armed, "fall_watching", got.fall_watching);
						end
					end
				end
				stall_left = no_idle ? 0 : $urandom_range(0, HoldMax);
			end else if (!out_ready && stall_left > 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
		end
	end

	// watchdog: any handshake or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("watchdog: no handshake for %0d cycles, %0d results still owed",
					quiet_cycles, awaited.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_click_arm_and_fire();
		test_cancel_while_armed();
		test_zero_count_and_window();
		test_fall_watch();
		test_random_reset_values();
		test_random_floor();
		test_random_ceiling();
		test_random_settings();

		settle();
		mismatches += awaited.size();
		$display("%0d ticks checked under %0d register settings: %0d sos alerts, %0d fall alerts",
			ticks_sent, settings_used, sos_fired, falls_fired);
		$display("%0d sos cancelled by a click while armed, %0d fall watches ended by movement",
			sos_cancels, watch_drops);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d bad or unmatched results", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sos_click_and_fall_alert_detector_top.f
sv/sacfd_pkg.sv
sv/sacfd_cfg.sv
sv/sacfd_sos.sv
sv/sacfd_fall.sv
sv/sos_click_and_fall_alert_detector_top.sv
tb/sos_click_and_fall_alert_detector_top_test.sv
